// File: hw/rtl/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder.
// Holds event and mouse kind codes and packet bit positions; no dependencies.
package ps2md_pkg;

  typedef enum logic [1:0] {
    EV_BUTTON = 2'd0,
    EV_MOVE   = 2'd1,
    EV_SCROLL = 2'd2
  } event_kind_e;

  localparam logic [1:0] KIND_STANDARD = 2'd0;
  localparam logic [1:0] KIND_WHEEL    = 2'd1;
  localparam logic [1:0] KIND_FIVE_BTN = 2'd2;

  localparam int unsigned NumButtons = 5;
  localparam int unsigned NumEvents  = NumButtons + 2;
  localparam int unsigned EvMoveBit   = NumButtons;
  localparam int unsigned EvScrollBit = NumButtons + 1;

  localparam int unsigned SyncBit  = 3;
  localparam int unsigned XSignBit = 4;
  localparam int unsigned YSignBit = 5;

  typedef logic [NumEvents-1:0] ev_mask_t;

endpackage

// File: hw/rtl/ps2_mouse_packet_decoder_top.sv
// Top level of the PS/2 mouse packet decoder.
// Depends on ps2md_pkg for event codes, mouse kinds and packet bit positions.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, rx_byte_i) takes one mouse byte
//   per transaction. Bytes are framed into 3- or 4-byte packets according to
//   mouse_kind, written through the config channel (cfg_valid_i, cfg_ready_o,
//   cfg_data_i); the user must write it only while the block is idle, which
//   the block does not enforce. cfg_ready_o is always high. A byte that does
//   not complete a packet is never stalled. A byte that completes a packet
//   is registered together with its pending event set; the events then
//   leave through the output channel (out_valid_o, out_stall_i) one per cycle,
//   buttons first (lowest index first), then move, then scroll. last_o marks
//   the final event of the packet. Events go from the pending set to the
//   output register. Throughput: one event per cycle while the receiver does
//   not stall; while events are pending, a further packet-completing byte
//   is stalled while the other bytes are still taken.
//   Reset clears framing position, button state, kind and all pending events.
//   When the receiver stalls, the output register holds its event and the
//   pending events wait behind it.
module ps2_mouse_packet_decoder_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output ps2md_pkg::event_kind_e   event_kind_o,
  output logic [2:0]               button_index_o,
  output logic                     pressed_o,
  output logic signed [8:0]        move_x_o,
  output logic signed [8:0]        move_y_o,
  output logic signed [3:0]        scroll_amount_o,
  output logic                     last_o
);
  import ps2md_pkg::*;

  logic [1:0]            kind_q;
  logic [1:0]            pos_q, pos_d;
  logic [7:0]            pb0_q, pb1_q, pb2_q;
  logic [NumButtons-1:0] btn_q, btn_d;
  ev_mask_t              ev_q, ev_d;
  logic [8:0]            x_q, y_q;
  logic [3:0]            z_q;
  logic [NumButtons-1:0] newbtn_q;

  logic                  four;
  logic                  completing;
  logic                  in_accept;
  logic                  ev_load;
  logic [7:0]            b3;
  logic [7:0]            ylow;
  logic [NumButtons-1:0] newmask;
  logic [8:0]            x_new, y_new;
  logic [3:0]            z_new;
  logic                  discard;

  logic                  out_valid_q;
  event_kind_e           kind_out_q, kind_out_d;
  logic [2:0]            idx_q, idx_d;
  logic                  pr_q, pr_d;
  logic [8:0]            ox_q, ox_d, oy_q, oy_d;
  logic [3:0]            oz_q, oz_d;
  logic                  last_q, last_d;
  logic                  out_load;
  ev_mask_t              ev_rest;

  assign cfg_ready_o = 1'b1;
  assign four        = (kind_q == KIND_WHEEL) || (kind_q == KIND_FIVE_BTN);
  assign completing  = ({1'b0, pos_q} + 3'd1) >= (four ? 3'd4 : 3'd3);
  assign in_stall_o  = completing && (ev_q != '0);
  assign in_accept   = in_valid_i && !in_stall_o;

  always_comb begin
    b3      = four ? rx_byte_i : 8'h00;
    ylow    = four ? pb2_q : rx_byte_i;
    discard = (kind_q == KIND_FIVE_BTN) && (b3[7:6] != 2'b00);
    newmask = {2'b00, pb0_q[2:0]};
    if (kind_q == KIND_FIVE_BTN) begin
      newmask[4:3] = b3[5:4];
    end
    x_new = {pb0_q[XSignBit], pb1_q};
    y_new = {pb0_q[YSignBit], ylow};
    z_new = b3[3:0];
  end

  assign ev_load = in_accept && completing && !discard;

  always_comb begin
    pos_d = pos_q;
    btn_d = btn_q;
    if (in_accept) begin
      if (pos_q == 2'd0 && !rx_byte_i[SyncBit]) begin
        pos_d = pos_q;
      end else if (completing) begin
        pos_d = 2'd0;
        if (!discard) begin
          btn_d = newmask;
        end
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && !completing && !(pos_q == 2'd0 && !rx_byte_i[SyncBit])) begin
      unique case (pos_q)
        2'd0:    pb0_q <= rx_byte_i;
        2'd1:    pb1_q <= rx_byte_i;
        default: pb2_q <= rx_byte_i;
      endcase
    end
    if (ev_load) begin
      x_q      <= x_new;
      y_q      <= y_new;
      z_q      <= z_new;
      newbtn_q <= newmask;
    end
  end

  always_comb begin
    kind_out_d = EV_BUTTON;
    idx_d      = 3'd0;
    pr_d       = 1'b0;
    ox_d       = 9'd0;
    oy_d       = 9'd0;
    oz_d       = 4'd0;
    ev_rest    = ev_q;
    for (int i = NumEvents - 1; i >= 0; i--) begin
      if (ev_q[i]) begin
        ev_rest = ev_q & ~(ev_mask_t'(1) << i);
        if (i < NumButtons) begin
          kind_out_d = EV_BUTTON;
          idx_d      = 3'(i);
          pr_d       = newbtn_q[i];
          ox_d       = 9'd0;
          oy_d       = 9'd0;
          oz_d       = 4'd0;
        end else if (i == EvMoveBit) begin
          kind_out_d = EV_MOVE;
          idx_d      = 3'd0;
          pr_d       = 1'b0;
          ox_d       = x_q;
          oy_d       = y_q;
          oz_d       = 4'd0;
        end else begin
          kind_out_d = EV_SCROLL;
          idx_d      = 3'd0;
          pr_d       = 1'b0;
          ox_d       = 9'd0;
          oy_d       = 9'd0;
          oz_d       = z_q;
        end
      end
    end
    last_d = (ev_rest == '0);
  end

  assign out_load = (ev_q != '0) && (!out_valid_q || !out_stall_i);

  always_comb begin
    ev_d = ev_q;
    if (ev_load) begin
      ev_d[NumButtons-1:0] = newmask ^ btn_q;
      ev_d[EvMoveBit]      = (x_new != 9'd0) || (y_new != 9'd0);
      ev_d[EvScrollBit]    = (z_new != 4'd0);
    end else if (out_load) begin
      ev_d = ev_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_STANDARD;
      pos_q       <= 2'd0;
      btn_q       <= '0;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        kind_q <= cfg_data_i;
      end
      pos_q <= pos_d;
      btn_q <= btn_d;
      ev_q  <= ev_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_out_q <= kind_out_d;
      idx_q      <= idx_d;
      pr_q       <= pr_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      oz_q       <= oz_d;
      last_q     <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_out_q;
  assign button_index_o  = idx_q;
  assign pressed_o       = pr_q;
  assign move_x_o        = ox_q;
  assign move_y_o        = oy_q;
  assign scroll_amount_o = oz_q;
  assign last_o          = last_q;

`ifndef SYNTH
  a_last_matches_pending: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (last_q == (ev_q == '0))
  ) else $error("last flag disagrees with pending event set");

  a_pending_drains: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ev_q != '0) && !out_valid_q |=> out_valid_q
  ) else $error("pending event not moved to output register");

  a_button_index_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_out_q == EV_BUTTON) |-> (idx_q < 3'(NumButtons))
  ) else $error("button index out of range");
`endif

endmodule
